/* design/iecho_pkg.sv */
`default_nettype none

package iecho_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTES_W = 3;
   localparam int TDATA_W = 40;
   localparam int PAD_W   = TDATA_W - WORD_W - BYTES_W;

   // depth of the output queue; the queue is built from flops, keep it 2..32
   localparam int FIFO_DEPTH = 8;

   localparam int HEAD_WORDS = 6;
   localparam int HEAD_IDX_W = 3;
   localparam logic [HEAD_IDX_W-1:0] LAST_HEAD_IDX = 3'd5;

   localparam logic [7:0]         ECHO_REQUEST = 8'd8;
   localparam logic [7:0]         ECHO_REPLY   = 8'd0;
   localparam logic [15:0]        TYPE_DELTA   = 16'h0800;
   localparam logic [3:0]         IHL_BASIC    = 4'd5;
   localparam logic [BYTES_W-1:0] FULL_BYTES   = 3'd4;

   // one queue entry: a plain word, or a marker that stands for the six reply header words
   typedef struct packed {
      logic                marker;
      logic [WORD_W-1:0]   word;
      logic                last;
      logic [BYTES_W-1:0]  bytes;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // byte counts outside 1..4 count as a full word
   function automatic logic [BYTES_W-1:0] norm_bytes(input logic [BYTES_W-1:0] raw);
      logic [BYTES_W-1:0] res;
      res = raw;
      if (raw == 3'd0 || raw > FULL_BYTES) begin
         res = FULL_BYTES;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* design/icmp_echo_reply_rewriter.sv */
// ICMP echo responder for IPv4 packets carried as 32-bit network-order words.
// req_ side takes one packet word per transaction: tdata[31:0] the word, first
// byte in bits 31..24, tdata[34:32] the valid byte count, tlast the final word.
// The first five words are held; at the sixth the packet is judged. An echo
// request with a 20-byte header comes out on rsp_ as an echo reply (type 0,
// addresses swapped, checksum patched), and its later words follow unchanged.
// Every other packet, and any packet under six full words, is dropped.
// With an empty queue a passed word shows on rsp_ in the cycle after its
// transaction; the reply header starts in the cycle after the sixth word and
// plays out as six words. Throughput: one word per cycle in and out while
// neither side stalls. Words wait in a FIFO_DEPTH entry output queue, so input
// is taken while results wait; req_tready falls when that queue is full, or
// when a sixth header word arrives before the last word of the previous reply
// header leaves the six-word bank. A stall on rsp_tready fills the queue and
// then holds off req_. Reset empties the queue and returns to waiting for the
// start of a packet; no clearing pass is needed.
`default_nettype none

module icmp_echo_reply_rewriter #(
   parameter int FIFO_DEPTH = iecho_pkg::FIFO_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // data_word [31:0], bytes_in_word [34:32], zero [39:35]
   input  wire logic [iecho_pkg::TDATA_W-1:0]  req_tdata,
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // word_out [31:0], bytes_out [34:32], zero [39:35]
   output logic [iecho_pkg::TDATA_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int W = iecho_pkg::WORD_W;

   logic [W-1:0] head_ff  [iecho_pkg::HEAD_WORDS-1];
   logic [W-1:0] reply_ff [iecho_pkg::HEAD_WORDS];
   logic [W-1:0] reply_in [iecho_pkg::HEAD_WORDS];

   logic [iecho_pkg::HEAD_IDX_W-1:0] word_index_ff, word_index_in;
   logic [iecho_pkg::HEAD_IDX_W-1:0] replay_ff, replay_in;
   logic dropping_ff, dropping_in;
   logic passing_ff, passing_in;
   logic bank_busy_ff, bank_busy_in;

   logic [W-1:0]                  req_word;
   logic [iecho_pkg::BYTES_W-1:0] bytes_n;
   logic                          req_fire, rsp_fire;
   logic                          hdr_phase, at_sixth;
   logic                          load, push, pop, replay_done;
   logic [16:0]                   sum_wide;
   logic [15:0]                   sum_fold;

   iecho_pkg::q_entry_type   push_entry, head_entry;
   iecho_pkg::fifo_stat_type q_stat;

   assign req_word  = req_tdata[W-1:0];
   assign bytes_n   = iecho_pkg::norm_bytes(req_tdata[W+iecho_pkg::BYTES_W-1:W]);
   assign hdr_phase = !passing_ff && !dropping_ff;
   assign at_sixth  = hdr_phase && (word_index_ff == iecho_pkg::LAST_HEAD_IDX);

   // the bank may be reloaded at the edge that sends its last word
   assign req_tready = !q_stat.full && !(at_sixth && bank_busy_ff && !replay_done);
   assign req_fire   = req_tvalid && req_tready;

   // checksum patch with end-around carry
   assign sum_wide = {1'b0, req_word[15:0]} + {1'b0, iecho_pkg::TYPE_DELTA};
   assign sum_fold = sum_wide[16] ? sum_wide[15:0] + 16'd1 : sum_wide[15:0];

   always_comb begin
      reply_in[0] = head_ff[0];
      reply_in[1] = head_ff[1];
      reply_in[2] = head_ff[2];
      reply_in[3] = head_ff[4];
      reply_in[4] = head_ff[3];
      reply_in[5] = {iecho_pkg::ECHO_REPLY, req_word[23:16], sum_fold};
   end

   always_comb begin
      word_index_in = word_index_ff;
      dropping_in   = dropping_ff;
      passing_in    = passing_ff;
      push          = 1'b0;
      load          = 1'b0;
      push_entry    = '0;
      if (req_fire) begin
         if (passing_ff) begin
            push             = 1'b1;
            push_entry.word  = req_word;
            push_entry.last  = req_tlast;
            push_entry.bytes = req_tlast ? bytes_n : iecho_pkg::FULL_BYTES;
            if (req_tlast) begin
               passing_in = 1'b0;
            end
         end else if (dropping_ff) begin
            if (req_tlast) begin
               dropping_in = 1'b0;
            end
         end else if (!at_sixth) begin
            word_index_in = req_tlast ? '0 : word_index_ff + 1'b1;
         end else begin
            word_index_in = '0;
            if (req_tlast && bytes_n != iecho_pkg::FULL_BYTES) begin
               // short packet, nothing to send
            end else if (head_ff[0][27:24] != iecho_pkg::IHL_BASIC
                         || req_word[31:24] != iecho_pkg::ECHO_REQUEST) begin
               dropping_in = !req_tlast;
            end else begin
               load              = 1'b1;
               push              = 1'b1;
               push_entry.marker = 1'b1;
               push_entry.last   = req_tlast;
               push_entry.bytes  = iecho_pkg::FULL_BYTES;
               passing_in        = !req_tlast;
            end
         end
      end
   end

   iecho_fifo #(
      .DEPTH(FIFO_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .stat       (q_stat)
   );

   // a marker entry plays out the reply bank, one word per transaction
   assign rsp_tvalid  = !q_stat.empty;
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign replay_done = rsp_fire && head_entry.marker
                        && (replay_ff == iecho_pkg::LAST_HEAD_IDX);
   assign pop         = rsp_fire && (!head_entry.marker || replay_done);

   always_comb begin
      if (head_entry.marker) begin
         rsp_tdata = {{iecho_pkg::PAD_W{1'b0}}, iecho_pkg::FULL_BYTES, reply_ff[replay_ff]};
         rsp_tlast = head_entry.last && (replay_ff == iecho_pkg::LAST_HEAD_IDX);
      end else begin
         rsp_tdata = {{iecho_pkg::PAD_W{1'b0}}, head_entry.bytes, head_entry.word};
         rsp_tlast = head_entry.last;
      end
   end

   always_comb begin
      replay_in = replay_ff;
      if (replay_done) begin
         replay_in = '0;
      end else if (rsp_fire && head_entry.marker) begin
         replay_in = replay_ff + 1'b1;
      end
      bank_busy_in = bank_busy_ff;
      if (load) begin
         bank_busy_in = 1'b1;
      end else if (replay_done) begin
         bank_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff <= '0;
         dropping_ff   <= 1'b0;
         passing_ff    <= 1'b0;
         bank_busy_ff  <= 1'b0;
         replay_ff     <= '0;
      end else begin
         word_index_ff <= word_index_in;
         dropping_ff   <= dropping_in;
         passing_ff    <= passing_in;
         bank_busy_ff  <= bank_busy_in;
         replay_ff     <= replay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && hdr_phase && !at_sixth) begin
         head_ff[word_index_ff] <= req_word;
      end
      if (load) begin
         reply_ff <= reply_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      load |-> (!bank_busy_ff || replay_done))
      else $error("reply bank reloaded while still in use");

   assert property (@(posedge clock) disable iff (reset) push |-> !q_stat.full)
      else $error("push into a full output queue");

   assert property (@(posedge clock) disable iff (reset)
      (replay_ff != '0) |-> (!q_stat.empty && head_entry.marker && bank_busy_ff))
      else $error("reply playout without a marker at the queue head");

   assert property (@(posedge clock) disable iff (reset) !(passing_ff && dropping_ff))
      else $error("packet both passing and dropping");

   assert property (@(posedge clock) disable iff (reset)
      (word_index_ff != '0) |-> (hdr_phase && word_index_ff <= iecho_pkg::LAST_HEAD_IDX))
      else $error("header index out of the header phase");

endmodule

`default_nettype wire

/* design/iecho_fifo.sv */
`default_nettype none

module iecho_fifo #(
   parameter int DEPTH = iecho_pkg::FIFO_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire iecho_pkg::q_entry_type  push_entry,
   input  wire logic                    pop,
   output iecho_pkg::q_entry_type       head_entry,
   output iecho_pkg::fifo_stat_type     stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   iecho_pkg::q_entry_type store_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* sim/icmp_echo_checker.sv */
`default_nettype none

module icmp_echo_checker
   import iecho_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   // data_word [31:0], bytes_in_word [34:32], zero [39:35]
   input  wire logic [TDATA_W-1:0] req_tdata,
   input  wire logic               req_tlast,
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   // word_out [31:0], bytes_out [34:32], zero [39:35]
   input  wire logic [TDATA_W-1:0] rsp_tdata,
   input  wire logic               rsp_tlast,
   output int                      errors,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic               last;
      logic [BYTES_W-1:0] bytes;
   } reply_word_type;

   reply_word_type    reply_q[$];
   logic [WORD_W-1:0] held_words [HEAD_WORDS];
   int                held_count = 0;
   logic              dropping = 1'b0;
   logic              passing = 1'b0;
   int                err_count = 0;
   int                pending_count = 0;

   assign errors  = err_count;
   assign pending = pending_count;

   // tracks one packet word and queues the reply words it releases
   task automatic predict_reply(input logic [WORD_W-1:0] w, input logic lst,
                                input logic [BYTES_W-1:0] raw);
      logic [BYTES_W-1:0] nb;
      logic [16:0]        sum;
      logic [WORD_W-1:0]  reply_icmp;
      nb = (raw >= 3'd1 && raw <= FULL_BYTES) ? raw : FULL_BYTES;
      if (passing) begin
         reply_q.push_back('{w, lst, lst ? nb : FULL_BYTES});
         if (lst) passing = 1'b0;
      end else if (dropping) begin
         if (lst) dropping = 1'b0;
      end else begin
         held_words[held_count] = w;
         held_count++;
         if (held_count == HEAD_WORDS) begin
            held_count = 0;
            // a short sixth word on the last transaction drops the packet
            if (!(lst && nb != FULL_BYTES)) begin
               if (held_words[0][27:24] != IHL_BASIC ||
                   held_words[HEAD_WORDS-1][31:24] != ECHO_REQUEST) begin
                  dropping = !lst;
               end else begin
                  sum = {1'b0, held_words[HEAD_WORDS-1][15:0]} + {1'b0, TYPE_DELTA};
                  reply_icmp = {ECHO_REPLY, held_words[HEAD_WORDS-1][23:16],
                                sum[15:0] + 16'(sum[16])};
                  reply_q.push_back('{held_words[0], 1'b0, FULL_BYTES});
                  reply_q.push_back('{held_words[1], 1'b0, FULL_BYTES});
                  reply_q.push_back('{held_words[2], 1'b0, FULL_BYTES});
                  // source and destination swap places
                  reply_q.push_back('{held_words[4], 1'b0, FULL_BYTES});
                  reply_q.push_back('{held_words[3], 1'b0, FULL_BYTES});
                  reply_q.push_back('{reply_icmp, lst, FULL_BYTES});
                  passing = !lst;
               end
            end
         end else if (lst) begin
            held_count = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      reply_word_type want;
      if (!reset) begin
         // output side first, so a word predicted at this edge cannot hide a stray one
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               $error("unexpected reply transaction: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== want.word) begin
                  $error("word_out: expected %h, actual %h", want.word, rsp_tdata[WORD_W-1:0]);
                  err_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_out: expected %b, actual %b", want.last, rsp_tlast);
                  err_count++;
               end
               if (rsp_tdata[WORD_W+:BYTES_W] !== want.bytes) begin
                  $error("bytes_out: expected %0d, actual %0d", want.bytes,
                         rsp_tdata[WORD_W+:BYTES_W]);
                  err_count++;
               end
               if (rsp_tdata[TDATA_W-1:WORD_W+BYTES_W] !== '0) begin
                  $error("tdata padding: expected %h, actual %h", {PAD_W{1'b0}},
                         rsp_tdata[TDATA_W-1:WORD_W+BYTES_W]);
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_reply(req_tdata[WORD_W-1:0], req_tlast, req_tdata[WORD_W+:BYTES_W]);
         end
      end
      pending_count = reply_q.size();
   end

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import iecho_pkg::*;

   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int RANDOM_WORDS     = 360;
   localparam int DRAIN_CYCLES     = 20;
   localparam int LONG_HOLD        = 100;
   localparam int HOLD_AFTER_WORDS = 120;

   typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARELY} ready_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tlast;
   int                 errors;
   int                 pending;

   int                 burst_left = 0;
   int                 words_sent = 0;
   int                 idle_cycles = 0;
   int                 echo_pkts = 0;
   int                 reject_pkts = 0;
   int                 short_pkts = 0;
   logic [WORD_W-1:0]  pkt_q[$];

   always #2 clock = ~clock;

   icmp_echo_reply_rewriter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   icmp_echo_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending)
   );

   function automatic logic [WORD_W-1:0] any_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [WORD_W-1:0] w, input logic lst,
                            input logic [BYTES_W-1:0] nb);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{PAD_W{1'b0}}, nb, w};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // byte counts of words before the last are ignored, so they run over all codes
   task automatic send_packet(input logic [BYTES_W-1:0] last_nb);
      for (int i = 0; i < pkt_q.size(); i++) begin
         send_word(pkt_q[i], i == pkt_q.size() - 1,
                   (i == pkt_q.size() - 1) ? last_nb : BYTES_W'($urandom_range(0, 7)));
      end
      pkt_q.delete();
   endtask

   task automatic make_header(input logic [3:0] ihl, input logic [7:0] icmp_kind,
                              input logic [15:0] csum);
      pkt_q.delete();
      pkt_q.push_back({4'h4, ihl, 24'($urandom)});
      repeat (4) pkt_q.push_back(any_word());
      pkt_q.push_back({icmp_kind, 8'($urandom), csum});
   endtask

   task automatic add_tail(input int n);
      repeat (n) pkt_q.push_back(any_word());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off once traffic is flowing
   initial begin : rsp_stall_pattern
      ready_mode_type mode;
      int             span;
      int             seen;
      logic           hold_done;
      seen = 0;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         mode = ready_mode_type'($urandom_range(0, 3));
         span = $urandom_range(5, 40);
         repeat (span) begin
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
            if (req_tvalid && req_tready) seen++;
         end
         if (!hold_done && seen >= HOLD_AFTER_WORDS) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int                 first_random;
      int                 pick;
      int                 tail;
      logic [BYTES_W-1:0] last_nb;
      logic [15:0]        csum;
      logic [7:0]         kind;
      logic [3:0]         ihl;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // six-word echo, checksum wraps with the end-around carry
      pkt_q = '{32'h4500_001C, 32'h0000_4000, 32'hFF01_0000, 32'h0A00_0001,
                32'hFFFF_FFFF, 32'h0800_FFFF};
      send_packet(FULL_BYTES);
      echo_pkts++;
      // echo with one tail word, byte count zero counts as full
      pkt_q = '{32'h4500_0020, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                32'h0A00_0002, 32'h08FF_F800, 32'hDEAD_BEEF};
      send_packet(3'd0);
      echo_pkts++;
      // packet that ends inside the header
      pkt_q = '{32'h4500_0008, 32'h1234_5678};
      send_packet(3'd7);
      short_pkts++;
      // sixth word last but not full: dropped
      make_header(IHL_BASIC, ECHO_REQUEST, 16'h1234);
      send_packet(3'd3);
      short_pkts++;
      // options present: whole packet dropped
      make_header(4'd6, ECHO_REQUEST, 16'hF7FF);
      add_tail(1);
      send_packet(3'd2);
      reject_pkts++;
      wait_drained();

      first_random = words_sent;
      while (words_sent - first_random < RANDOM_WORDS) begin
         pick = $urandom_range(0, 19);
         tail = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
         last_nb = BYTES_W'($urandom_range(0, 7));
         if (pick == 19) wait_drained();
         if (pick <= 12 || pick == 19) begin
            csum = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hF7FF, 16'hFFFF))
                                               : 16'($urandom);
            make_header(IHL_BASIC, ECHO_REQUEST, csum);
            if (tail == 0 && $urandom_range(0, 1) == 1) last_nb = FULL_BYTES;
            echo_pkts++;
         end else if (pick <= 14) begin
            if ($urandom_range(0, 1) == 1) begin
               kind = ECHO_REPLY;
            end else begin
               do kind = 8'($urandom); while (kind == ECHO_REQUEST);
            end
            make_header(IHL_BASIC, kind, 16'($urandom));
            reject_pkts++;
         end else if (pick == 15) begin
            do ihl = 4'($urandom); while (ihl == IHL_BASIC);
            make_header(ihl, ECHO_REQUEST, 16'($urandom));
            reject_pkts++;
         end else begin
            // short packets and raw noise
            pkt_q.delete();
            add_tail((pick <= 17) ? $urandom_range(1, 5) : $urandom_range(1, 12));
            short_pkts++;
         end
         if (pick <= 15 || pick == 19) add_tail(tail);
         send_packet(last_nb);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("sent %0d words in %0d packets: %0d echo requests, %0d rejected headers,",
               words_sent, echo_pkts + reject_pkts + short_pkts, echo_pkts, reject_pkts);
      $display("%0d short or noise packets; receiver held off %0d cycles once",
               short_pkts, LONG_HOLD);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/iecho_pkg.sv
design/iecho_fifo.sv
design/icmp_echo_reply_rewriter.sv
sim/icmp_echo_checker.sv
sim/testbench.sv
